@@ src/wsc_pkg.sv @@
// Shared definitions for the wall segment collision core.
// No dependencies; imported by wall_segment_collision_core.
package wsc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        REG_WALL_START_X = 2'd0,
        REG_WALL_START_Y = 2'd1,
        REG_WALL_END_X   = 2'd2,
        REG_WALL_END_Y   = 2'd3
    } wsc_reg_t;

    typedef enum logic {
        OP_SEGMENT = 1'b0,
        OP_CIRCLE  = 1'b1
    } wsc_op_t;

endpackage

@@ src/wall_segment_collision_core.sv @@
// Top level of the wall segment collision core: streaming query pipeline.
// Depends on wsc_pkg.
//
// Usage:
//  - cfg channel writes one wall coordinate per transfer (index 0..3: start x,
//    start y, end x, end y). Always ready. Write only while no query is in
//    flight.
//  - s_axis carries one query per transfer. tuser is the opcode (0 = moving
//    segment crossing test, 1 = circle touch test); tdata packs point, target
//    and radius.
//  - m_axis returns one result per query in order. tuser is the hit flag,
//    tdata the crossing point in fixed point with FRAC_BITS fraction bits.
//  - Throughput: one query per cycle while the receiver is not stalling. The
//    crossing point comes from a divider pipeline, which resolves one bit of
//    the quotient per stage.
//  - Stages: operand differences, products, sums, sign fixup and circle
//    partial products, circle compare, divider bits, output register.
//  - When the receiver stalls with a result held, the whole pipeline freezes
//    and s_axis_tready drops; nothing is lost or repeated.
//  - Reset clears all valid bits and the wall registers to zero.
module wall_segment_collision_core
    import wsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data,
    // query stream
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: point_x, point_y, target_x, target_y, radius, zero pad
    input  logic [((5*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
    // tuser: opcode
    input  logic s_axis_tuser,
    // result stream
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: cross_x, cross_y, zero pad
    output logic [((2*(COORD_BITS+FRAC_BITS)+7)/8)*8-1:0] m_axis_tdata,
    // tuser: hit
    output logic m_axis_tuser
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int D    = C + 1;          // coordinate difference
    localparam int P    = 2 * D;          // product
    localparam int S    = 2 * D + 1;      // sum of products
    localparam int HL   = (S + 1) / 2;    // low half for split multiplies
    localparam int HH   = S - HL;
    localparam int W2   = 2 * S;          // squared compare width
    localparam int R2W  = 2 * C - 2;      // radius squared
    localparam int NDIV = C + F;          // quotient bits = divider stages
    localparam int RW   = S + 2;          // divider remainder
    localparam int OW   = C + F;          // output coordinate
    localparam int OTW  = ((2 * OW + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Wall registers
    // ------------------------------------------------------------------
    logic [C-1:0] wsx_reg, wsy_reg, wex_reg, wey_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsx_reg <= '0;
            wsy_reg <= '0;
            wex_reg <= '0;
            wey_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (wsc_reg_t'(cfg_index))
                REG_WALL_START_X: wsx_reg <= cfg_data;
                REG_WALL_START_Y: wsy_reg <= cfg_data;
                REG_WALL_END_X:   wex_reg <= cfg_data;
                REG_WALL_END_Y:   wey_reg <= cfg_data;
                default:          wsx_reg <= wsx_reg;
            endcase
        end
    end

    // wall direction; the user must keep it static while queries are in flight (not enforced here)
    logic signed [D-1:0] lx, ly, lxa, lya;
    logic [NDIV-1:0]     magx, magy;
    assign lx   = {wex_reg[C-1], wex_reg} - {wsx_reg[C-1], wsx_reg};
    assign ly   = {wey_reg[C-1], wey_reg} - {wsy_reg[C-1], wsy_reg};
    assign lxa  = lx[D-1] ? -lx : lx;
    assign lya  = ly[D-1] ? -ly : ly;
    assign magx = NDIV'(lxa) << F;
    assign magy = NDIV'(lya) << F;

    // global advance: freeze everything while the output is held
    logic en;
    logic ov_reg;
    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: differences
    // ------------------------------------------------------------------
    logic [C-1:0] in_px, in_py, in_tx, in_ty;
    logic [C-2:0] in_r;
    assign in_px = s_axis_tdata[0*C +: C];
    assign in_py = s_axis_tdata[1*C +: C];
    assign in_tx = s_axis_tdata[2*C +: C];
    assign in_ty = s_axis_tdata[3*C +: C];
    assign in_r  = s_axis_tdata[4*C +: C-1];

    logic                v1_reg, op1_reg;
    logic signed [D-1:0] vx1_reg, vy1_reg, mx1_reg, my1_reg;
    logic signed [D-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic [C-2:0]        r1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= s_axis_tuser;
            vx1_reg <= {wsx_reg[C-1], wsx_reg} - {in_px[C-1], in_px};
            vy1_reg <= {wsy_reg[C-1], wsy_reg} - {in_py[C-1], in_py};
            mx1_reg <= {in_tx[C-1], in_tx} - {in_px[C-1], in_px};
            my1_reg <= {in_ty[C-1], in_ty} - {in_py[C-1], in_py};
            ax1_reg <= {in_px[C-1], in_px} - {wsx_reg[C-1], wsx_reg};
            ay1_reg <= {in_py[C-1], in_py} - {wsy_reg[C-1], wsy_reg};
            bx1_reg <= {in_px[C-1], in_px} - {wex_reg[C-1], wex_reg};
            by1_reg <= {in_py[C-1], in_py} - {wey_reg[C-1], wey_reg};
            r1_reg  <= in_r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products
    // ------------------------------------------------------------------
    logic                v2_reg, op2_reg;
    logic signed [P-1:0] mxly2_reg, mylx2_reg, vxly2_reg, vylx2_reg;
    logic signed [P-1:0] vxmy2_reg, vymx2_reg;
    logic signed [P-1:0] axax2_reg, ayay2_reg, bxbx2_reg, byby2_reg;
    logic signed [P-1:0] lxlx2_reg, lyly2_reg, lxay2_reg, lyax2_reg;
    logic signed [P-1:0] lxax2_reg, lyay2_reg;
    logic [R2W-1:0]      rr2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg   <= op1_reg;
            mxly2_reg <= mx1_reg * ly;
            mylx2_reg <= my1_reg * lx;
            vxly2_reg <= vx1_reg * ly;
            vylx2_reg <= vy1_reg * lx;
            vxmy2_reg <= vx1_reg * my1_reg;
            vymx2_reg <= vy1_reg * mx1_reg;
            axax2_reg <= ax1_reg * ax1_reg;
            ayay2_reg <= ay1_reg * ay1_reg;
            bxbx2_reg <= bx1_reg * bx1_reg;
            byby2_reg <= by1_reg * by1_reg;
            lxlx2_reg <= lx * lx;
            lyly2_reg <= ly * ly;
            lxay2_reg <= lx * ay1_reg;
            lyax2_reg <= ly * ax1_reg;
            lxax2_reg <= lx * ax1_reg;
            lyay2_reg <= ly * ay1_reg;
            rr2_reg   <= R2W'(r1_reg) * R2W'(r1_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums
    // ------------------------------------------------------------------
    logic                v3_reg, op3_reg;
    logic signed [S-1:0] den3_reg, n13_reg, n23_reg;
    logic signed [S-1:0] a23_reg, b23_reg, len3_reg, cr3_reg, dt3_reg;
    logic [R2W-1:0]      rr3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op3_reg  <= op2_reg;
            den3_reg <= S'(mxly2_reg) - S'(mylx2_reg);
            n13_reg  <= S'(vxly2_reg) - S'(vylx2_reg);
            n23_reg  <= S'(vxmy2_reg) - S'(vymx2_reg);
            a23_reg  <= S'(axax2_reg) + S'(ayay2_reg);
            b23_reg  <= S'(bxbx2_reg) + S'(byby2_reg);
            len3_reg <= S'(lxlx2_reg) + S'(lyly2_reg);
            cr3_reg  <= S'(lxay2_reg) - S'(lyax2_reg);
            dt3_reg  <= S'(lxax2_reg) + S'(lyay2_reg);
            rr3_reg  <= rr2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sign fixup, segment hit, circle partial products
    // ------------------------------------------------------------------
    logic signed [S-1:0] den_a, n1_s, n2_s, cr_a;
    logic                seg_hit;
    assign den_a   = den3_reg[S-1] ? -den3_reg : den3_reg;
    assign n1_s    = den3_reg[S-1] ? -n13_reg  : n13_reg;
    assign n2_s    = den3_reg[S-1] ? -n23_reg  : n23_reg;
    assign cr_a    = cr3_reg[S-1]  ? -cr3_reg  : cr3_reg;
    assign seg_hit = (den3_reg != '0) && !n1_s[S-1] && (n1_s <= den_a)
                   && !n2_s[S-1] && (n2_s <= den_a);

    logic                v4_reg, op4_reg, shit4_reg;
    logic [S-1:0]        den4_reg, n4_reg;
    logic [2*HH-1:0]     cchh4_reg;
    logic [HH+HL-1:0]    cchl4_reg;
    logic [2*HL-1:0]     ccll4_reg;
    logic [R2W+HH-1:0]   rlh4_reg;
    logic [R2W+HL-1:0]   rll4_reg;
    logic                lz4_reg, alt4_reg, blt4_reg, dtok4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op4_reg   <= op3_reg;
            shit4_reg <= seg_hit;
            den4_reg  <= den_a;
            n4_reg    <= n2_s;
            cchh4_reg <= (2*HH)'(cr_a[S-1:HL]) * (2*HH)'(cr_a[S-1:HL]);
            cchl4_reg <= (HH+HL)'(cr_a[S-1:HL]) * (HH+HL)'(cr_a[HL-1:0]);
            ccll4_reg <= (2*HL)'(cr_a[HL-1:0]) * (2*HL)'(cr_a[HL-1:0]);
            rlh4_reg  <= (R2W+HH)'(rr3_reg) * (R2W+HH)'(len3_reg[S-1:HL]);
            rll4_reg  <= (R2W+HL)'(rr3_reg) * (R2W+HL)'(len3_reg[HL-1:0]);
            lz4_reg   <= (len3_reg == '0);
            alt4_reg  <= a23_reg < S'(rr3_reg);
            blt4_reg  <= b23_reg < S'(rr3_reg);
            dtok4_reg <= !dt3_reg[S-1] && (dt3_reg <= len3_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5 (divider entry): circle compare, final hit
    // ------------------------------------------------------------------
    logic [W2-1:0] crsq, rlsq;
    logic          circ_hit;
    assign crsq = (W2'(cchh4_reg) << (2 * HL)) + (W2'(cchl4_reg) << (HL + 1))
                + W2'(ccll4_reg);
    assign rlsq = (W2'(rlh4_reg) << HL) + W2'(rll4_reg);
    assign circ_hit = lz4_reg ? alt4_reg
                    : (!(crsq > rlsq) && (dtok4_reg || alt4_reg || blt4_reg));

    // divider pipeline, one quotient bit per stage (index 0 = entry)
    logic            dv_reg   [0:NDIV];
    logic            dop_reg  [0:NDIV];
    logic            dhit_reg [0:NDIV];
    logic [S-1:0]    dn_reg   [0:NDIV];
    logic [S-1:0]    dden_reg [0:NDIV];
    logic [RW-1:0]   drx_reg  [0:NDIV];
    logic [RW-1:0]   dry_reg  [0:NDIV];
    logic [NDIV-1:0] dqx_reg  [0:NDIV];
    logic [NDIV-1:0] dqy_reg  [0:NDIV];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dop_reg[0]  <= op4_reg;
            dhit_reg[0] <= (op4_reg == OP_CIRCLE) ? circ_hit : shit4_reg;
            dn_reg[0]   <= n4_reg;
            dden_reg[0] <= den4_reg;
            drx_reg[0]  <= '0;
            dry_reg[0]  <= '0;
            dqx_reg[0]  <= '0;
            dqy_reg[0]  <= '0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= NDIV; k++)
        begin : g_div
            logic [RW-1:0]   tx, ty, d1, d2;
            logic [RW-1:0]   rx_next, ry_next;
            logic [NDIV-1:0] qx_next, qy_next;

            assign d1 = RW'(dden_reg[k-1]);
            assign d2 = RW'(dden_reg[k-1]) << 1;
            assign tx = (drx_reg[k-1] << 1)
                      + (magx[NDIV-k] ? RW'(dn_reg[k-1]) : '0);
            assign ty = (dry_reg[k-1] << 1)
                      + (magy[NDIV-k] ? RW'(dn_reg[k-1]) : '0);

            always_comb
            begin
                if (tx >= d2)
                begin
                    rx_next = tx - d2;
                    qx_next = (dqx_reg[k-1] << 1) + NDIV'(2);
                end
                else if (tx >= d1)
                begin
                    rx_next = tx - d1;
                    qx_next = (dqx_reg[k-1] << 1) + NDIV'(1);
                end
                else
                begin
                    rx_next = tx;
                    qx_next = dqx_reg[k-1] << 1;
                end
                if (ty >= d2)
                begin
                    ry_next = ty - d2;
                    qy_next = (dqy_reg[k-1] << 1) + NDIV'(2);
                end
                else if (ty >= d1)
                begin
                    ry_next = ty - d1;
                    qy_next = (dqy_reg[k-1] << 1) + NDIV'(1);
                end
                else
                begin
                    ry_next = ty;
                    qy_next = dqy_reg[k-1] << 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[k] <= 1'b0;
                else if (en)
                    dv_reg[k] <= dv_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dop_reg[k]  <= dop_reg[k-1];
                    dhit_reg[k] <= dhit_reg[k-1];
                    dn_reg[k]   <= dn_reg[k-1];
                    dden_reg[k] <= dden_reg[k-1];
                    drx_reg[k]  <= rx_next;
                    dry_reg[k]  <= ry_next;
                    dqx_reg[k]  <= qx_next;
                    dqy_reg[k]  <= qy_next;
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output stage: floor-signed offset plus wall start, in Q format
    // ------------------------------------------------------------------
    logic signed [OW+1:0] basex, basey, qxe, qye, offx, offy, vx_c, vy_c;
    logic signed [OW+1:0] rnzx, rnzy;
    logic                 seg_out;
    assign basex = (OW + 2)'($signed(wsx_reg)) <<< F;
    assign basey = (OW + 2)'($signed(wsy_reg)) <<< F;
    assign qxe   = (OW + 2)'(dqx_reg[NDIV]);
    assign qye   = (OW + 2)'(dqy_reg[NDIV]);
    assign rnzx  = (OW + 2)'(drx_reg[NDIV] != '0);
    assign rnzy  = (OW + 2)'(dry_reg[NDIV] != '0);
    assign offx  = lx[D-1] ? (-qxe - rnzx) : qxe;
    assign offy  = ly[D-1] ? (-qye - rnzy) : qye;
    assign vx_c  = basex + offx;
    assign vy_c  = basey + offy;
    assign seg_out = (dop_reg[NDIV] == OP_SEGMENT) && dhit_reg[NDIV];

    logic          hit_reg;
    logic [OW-1:0] cx_reg, cy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= dhit_reg[NDIV];
            cx_reg  <= seg_out ? vx_c[OW-1:0] : '0;
            cy_reg  <= seg_out ? vy_c[OW-1:0] : '0;
        end
    end

    // valid chain for the front stages and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_axis_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            ov_reg    <= dv_reg[NDIV];
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = OTW'({cy_reg, cx_reg});

endmodule
